// ----- hdl/csem_pkg.sv -----
package csem_pkg;

  // Default sizes of the wait queue and of a stored task id
  localparam int CSEM_QUEUE_DEPTH  = 16;
  localparam int CSEM_TASK_ID_BITS = 8;

  // Fixed field widths on the streaming ports
  localparam int TASK_W  = 8;
  localparam int COUNT_W = 16;
  localparam int INIT_W  = 15;
  localparam int DATA_W  = TASK_W + COUNT_W;
  // Kept adjustment: value minus initial count spans -65535..32767
  localparam int ADJ_W   = 18;
  // Working width for the value plus a release count
  localparam int SUM_W   = ADJ_W + 1;

  // Request kind carried in in_tuser
  localparam logic MODE_WAIT   = 1'b0;
  localparam logic MODE_SIGNAL = 1'b1;

  // Result kind carried in out_tuser
  typedef enum logic [2:0] {
    KIND_PASSED   = 3'd0,
    KIND_BLOCKED  = 3'd1,
    KIND_RELEASED = 3'd2,
    KIND_SIG_DONE = 3'd3,
    KIND_REFUSED  = 3'd4
  } csem_kind_t;

  // Saturate a working sum to the 16-bit semaphore range
  function automatic logic signed [COUNT_W-1:0] csem_clamp(input logic signed [SUM_W-1:0] x);
    logic signed [COUNT_W-1:0] r;
    if (x > SUM_W'(32767)) begin
      r = 16'sh7FFF;
    end else if (x < -SUM_W'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = x[COUNT_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- hdl/counting_semaphore_wait_queue_top.sv -----
// Sequence: a request is accepted in ST_IDLE and evaluated in ST_EXEC; a wait or a
//   negative signal registers its single result in ST_EXEC once the output is free.
// Flow: one request at a time; a signal releases its tasks from ST_EMIT, one read per
//   cycle from the wait queue memory while the output is free, then ends in ST_FIN.
// Reset (rst_n low, synchronous): initial count, value adjustment, queue pointers
//   and occupancy clear; queue memory contents are left as they are.
module counting_semaphore_wait_queue_top
  import csem_pkg::*;
#(
  parameter int QUEUE_DEPTH  = CSEM_QUEUE_DEPTH,
  parameter int TASK_ID_BITS = CSEM_TASK_ID_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  // Configuration: initial_count
  input  logic              cfg_wr_en,
  input  logic [INIT_W-1:0] cfg_wr_data,
  // Request channel
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // task_id[7:0], signal_count[23:8]
  input  logic              in_tuser,   // mode
  // Result channel
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // released_task[7:0], return_value[23:8]
  output logic [2:0]        out_tuser,  // result_kind
  output logic              out_tlast   // last
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int EXT_W = TASK_ID_BITS + TASK_W;

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_EMIT, ST_FIN} state_t;

  state_t                     state_r, state_nxt;
  logic [INIT_W-1:0]          init_r;
  logic signed [ADJ_W-1:0]    adj_r, adj_nxt;
  logic [PTR_W-1:0]           head_r, head_nxt, tail_r, tail_nxt;
  logic [CNT_W-1:0]           occ_r, occ_nxt, rel_left_r, rel_left_nxt;
  logic                       mode_r, mode_nxt;
  logic [TASK_W-1:0]          task_r, task_nxt;
  logic signed [COUNT_W-1:0]  n_r, n_nxt, ret_r, ret_nxt;
  logic                       out_valid_r, out_valid_nxt;
  csem_kind_t                 kind_r, kind_nxt;
  logic [TASK_W-1:0]          otask_r, otask_nxt;
  logic signed [COUNT_W-1:0]  oret_r, oret_nxt;
  logic                       olast_r, olast_nxt;

  logic                       out_free;
  logic signed [ADJ_W-1:0]    val;
  logic signed [SUM_W-1:0]    val_w;
  logic [CNT_W-1:0]           rel_cnt;
  logic signed [COUNT_W-1:0]  new_val;
  logic                       mem_wr_en, mem_rd_en;
  logic [TASK_ID_BITS-1:0]    mem_rd_data, task_masked;
  logic [EXT_W-1:0]           task_in_ext, task_q_ext, task_rd_ext;

  // Task id masked to the stored width and back to the port width
  assign task_in_ext = {{TASK_ID_BITS{1'b0}}, task_r};
  assign task_masked = task_in_ext[TASK_ID_BITS-1:0];
  assign task_q_ext  = {{TASK_W{1'b0}}, task_masked};
  assign task_rd_ext = {{TASK_W{1'b0}}, mem_rd_data};

  csem_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (TASK_ID_BITS)
  ) u_queue (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (tail_r),
    .wr_data (task_masked),
    .rd_en   (mem_rd_en),
    .rd_addr (head_r),
    .rd_data (mem_rd_data)
  );

  // Current semaphore value
  assign val   = $signed({3'b000, init_r}) + adj_r;
  assign val_w = {val[ADJ_W-1], val};

  // Tasks a signal releases: min(n, occupancy), or one for n == 0 on a negative value
  always_comb begin
    if (n_r == '0) begin
      rel_cnt = (val < 0 && occ_r != '0) ? CNT_W'(1) : '0;
    end else if (n_r > $signed({{(COUNT_W-CNT_W){1'b0}}, occ_r})) begin
      rel_cnt = occ_r;
    end else begin
      rel_cnt = n_r[CNT_W-1:0];
    end
  end

  assign out_free = !out_valid_r || out_tready;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    adj_nxt       = adj_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    occ_nxt       = occ_r;
    rel_left_nxt  = rel_left_r;
    mode_nxt      = mode_r;
    task_nxt      = task_r;
    n_nxt         = n_r;
    ret_nxt       = ret_r;
    out_valid_nxt = out_valid_r && !out_tready;
    kind_nxt      = kind_r;
    otask_nxt     = otask_r;
    oret_nxt      = oret_r;
    olast_nxt     = olast_r;
    mem_wr_en     = 1'b0;
    mem_rd_en     = 1'b0;
    new_val       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          mode_nxt  = in_tuser;
          task_nxt  = in_tdata[TASK_W-1:0];
          n_nxt     = $signed(in_tdata[DATA_W-1:TASK_W]);
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        if (mode_r == MODE_WAIT) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            olast_nxt     = 1'b1;
            state_nxt     = ST_IDLE;
            if (val > 0) begin
              new_val   = csem_clamp(val_w - SUM_W'(1));
              adj_nxt   = ADJ_W'(new_val) - $signed({3'b000, init_r});
              kind_nxt  = KIND_PASSED;
              otask_nxt = '0;
              oret_nxt  = 16'sd1;
            end else if (occ_r == CNT_W'(QUEUE_DEPTH)) begin
              kind_nxt  = KIND_REFUSED;
              otask_nxt = '0;
              oret_nxt  = '0;
            end else begin
              new_val   = csem_clamp(val_w - SUM_W'(1));
              adj_nxt   = ADJ_W'(new_val) - $signed({3'b000, init_r});
              mem_wr_en = 1'b1;
              tail_nxt  = (tail_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
              occ_nxt   = occ_r + 1'b1;
              kind_nxt  = KIND_BLOCKED;
              otask_nxt = task_q_ext[TASK_W-1:0];
              oret_nxt  = '0;
            end
          end
        end else if (n_r < 0) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            kind_nxt      = KIND_SIG_DONE;
            otask_nxt     = '0;
            oret_nxt      = n_r;
            olast_nxt     = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else begin
          // Value moves once up front; releases then drain the queue head
          if (n_r == '0) begin
            new_val = csem_clamp(val_w + SUM_W'(1));
            ret_nxt = '0;
          end else begin
            new_val = csem_clamp(val_w + $signed({{(SUM_W-CNT_W){1'b0}}, rel_cnt}));
            ret_nxt = $signed({{(COUNT_W-CNT_W){1'b0}}, rel_cnt});
          end
          adj_nxt = ADJ_W'(new_val) - $signed({3'b000, init_r});
          if (rel_cnt != '0) begin
            mem_rd_en    = 1'b1;
            head_nxt     = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
            occ_nxt      = occ_r - 1'b1;
            rel_left_nxt = rel_cnt - 1'b1;
            state_nxt    = ST_EMIT;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_RELEASED;
          otask_nxt     = task_rd_ext[TASK_W-1:0];
          oret_nxt      = '0;
          olast_nxt     = 1'b0;
          if (rel_left_r != '0) begin
            mem_rd_en    = 1'b1;
            head_nxt     = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
            occ_nxt      = occ_r - 1'b1;
            rel_left_nxt = rel_left_r - 1'b1;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end

      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_SIG_DONE;
          otask_nxt     = '0;
          oret_nxt      = ret_r;
          olast_nxt     = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // State, counters and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      init_r      <= '0;
      adj_r       <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      rel_left_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= cfg_wr_en ? cfg_wr_data : init_r;
      adj_r       <= adj_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
      rel_left_r  <= rel_left_nxt;
      out_valid_r <= out_valid_nxt;
      mode_r      <= mode_nxt;
      task_r      <= task_nxt;
      n_r         <= n_nxt;
      ret_r       <= ret_nxt;
      kind_r      <= kind_nxt;
      otask_r     <= otask_nxt;
      oret_r      <= oret_nxt;
      olast_r     <= olast_nxt;
    end
  end

  assign in_tready  = rst_n && (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {oret_r, otask_r};
  assign out_tuser  = kind_r;
  assign out_tlast  = olast_r;

endmodule

// ----- hdl/csem_ram.sv -----
module csem_ram
  import csem_pkg::*;
#(
  parameter int DEPTH = CSEM_QUEUE_DEPTH,
  parameter int WIDTH = CSEM_TASK_ID_BITS
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/csem_chk.sv -----
module csem_chk
  import csem_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [DATA_W-1:0] out_tdata,
  input logic [2:0]        out_tuser,
  input logic              out_tlast
);

  // One request in flight: no acceptance on the cycle after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while previous one in flight");

  // Only task releases may precede the final result of a request
  a_nonlast_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_tuser == KIND_RELEASED))
    else $error("non-final result is not a release");

  // A passing wait returns one and names no task
  a_pass_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_PASSED) |-> (out_tdata == 24'h000100 && out_tlast))
    else $error("passed result payload wrong");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast)))
    else $error("stalled result changed");

endmodule

bind counting_semaphore_wait_queue_top csem_chk u_csem_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ----- dv/semaphore_checker.sv -----
`timescale 1ns / 100ps

// Watches the config port and both stream channels, keeps its own model of the
// semaphore and its wait queue, and compares every result against it.
module semaphore_checker
  import csem_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [INIT_W-1:0] cfg_wr_data,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // task_id[7:0], signal_count[23:8]
  input  logic              in_tuser,   // mode
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [DATA_W-1:0] out_tdata,  // released_task[7:0], return_value[23:8]
  input  logic [2:0]        out_tuser,  // result_kind
  input  logic              out_tlast,
  output int                fail_count,
  output int                outstanding
);

  // Ring of predicted results; far deeper than one request can produce
  localparam int PEND_DEPTH = 256;

  typedef struct packed {
    csem_kind_t               kind;
    logic [TASK_W-1:0]        task_id;
    logic signed [COUNT_W-1:0] ret;
    logic                     last;
  } sem_result_t;

  // Model state
  logic [INIT_W-1:0] init_count;
  int                value_adj;
  logic [TASK_W-1:0] waiters [CSEM_QUEUE_DEPTH];
  int                q_head;
  int                q_tail;
  int                q_occ;
  sem_result_t       pend_buf [PEND_DEPTH];
  int                pend_wr;
  int                pend_rd;

  // Store a new semaphore value, clamped to 16 bits signed
  task automatic store_value(input int v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    value_adj = v - int'(init_count);
  endtask

  task automatic add_result(input csem_kind_t kind, input logic [TASK_W-1:0] tid,
                            input int ret, input logic last);
    sem_result_t r;
    r.kind    = kind;
    r.task_id = tid;
    r.ret     = COUNT_W'(ret);
    r.last    = last;
    pend_buf[pend_wr % PEND_DEPTH] = r;
    pend_wr++;
  endtask

  task automatic release_head();
    add_result(KIND_RELEASED, waiters[q_head], 0, 1'b0);
    q_head = (q_head + 1) % CSEM_QUEUE_DEPTH;
    q_occ--;
  endtask

  // Predict the results of one wait or signal request
  task automatic predict_semaphore_op(input logic mode, input logic [TASK_W-1:0] tid,
                                      input logic signed [COUNT_W-1:0] n);
    int v;
    int cnt;
    v = int'(init_count) + value_adj;
    if (mode == MODE_WAIT) begin
      if (v - 1 >= 0) begin
        store_value(v - 1);
        add_result(KIND_PASSED, '0, 1, 1'b1);
      end else if (q_occ >= CSEM_QUEUE_DEPTH) begin
        add_result(KIND_REFUSED, '0, 0, 1'b1);
      end else begin
        store_value(v - 1);
        waiters[q_tail] = tid;
        q_tail = (q_tail + 1) % CSEM_QUEUE_DEPTH;
        q_occ++;
        add_result(KIND_BLOCKED, tid, 0, 1'b1);
      end
    end else if (n < 0) begin
      add_result(KIND_SIG_DONE, '0, int'(n), 1'b1);
    end else if (n == 0) begin
      store_value(v + 1);
      // only a negative old value hands the semaphore to a waiter
      if (v < 0 && q_occ > 0) release_head();
      add_result(KIND_SIG_DONE, '0, 0, 1'b1);
    end else begin
      cnt = (int'(n) > q_occ) ? q_occ : int'(n);
      repeat (cnt) release_head();
      store_value(v + cnt);
      add_result(KIND_SIG_DONE, '0, cnt, 1'b1);
    end
  endtask

  // Check results, then take new requests and config writes
  always @(posedge clk) begin : monitor
    sem_result_t want;
    logic        bad;
    if (!rst_n) begin
      init_count = '0;
      value_adj  = 0;
      q_head     = 0;
      q_tail     = 0;
      q_occ      = 0;
      pend_wr    = 0;
      pend_rd    = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pend_wr == pend_rd) begin
          $display("%0t: result with nothing pending: kind %0d task %0d ret %0d last %0b",
                   $time, out_tuser, out_tdata[7:0], $signed(out_tdata[23:8]), out_tlast);
          fail_count++;
        end else begin
          want = pend_buf[pend_rd % PEND_DEPTH];
          pend_rd++;
          bad  = 1'b0;
          if (out_tuser !== want.kind) begin
            $display("%0t: result_kind expected %0d actual %0d", $time, want.kind, out_tuser);
            bad = 1'b1;
          end
          if (out_tdata[7:0] !== want.task_id) begin
            $display("%0t: released_task expected %0d actual %0d",
                     $time, want.task_id, out_tdata[7:0]);
            bad = 1'b1;
          end
          if (out_tdata[23:8] !== want.ret) begin
            $display("%0t: return_value expected %0d actual %0d",
                     $time, want.ret, $signed(out_tdata[23:8]));
            bad = 1'b1;
          end
          if (out_tlast !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, out_tlast);
            bad = 1'b1;
          end
          if (bad) fail_count++;
        end
      end
      if (in_tvalid && in_tready) begin
        predict_semaphore_op(in_tuser, in_tdata[7:0], in_tdata[23:8]);
      end
      if (cfg_wr_en) begin
        init_count = cfg_wr_data;
      end
    end
    outstanding = pend_wr - pend_rd;
  end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import csem_pkg::*;

  localparam int STUCK_LIMIT = 2000;
  localparam int PHASE_REQS  = 57;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [INIT_W-1:0] cfg_wr_data;
  logic              in_tvalid;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata;
  logic              in_tuser;
  logic              out_tvalid;
  logic              out_tready = 1'b1;
  logic [DATA_W-1:0] out_tdata;
  logic [2:0]        out_tuser;
  logic              out_tlast;

  int fail_count;
  int outstanding;
  bit quiet = 1'b0;
  int stall_left = 0;
  int stuck_cycles = 0;

  counting_semaphore_wait_queue_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  semaphore_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result side backpressure in random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready = 1'b0;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_tready = 1'b0;
      stall_left = $urandom_range(1, 7) - 1;
    end else begin
      out_tready = 1'b1;
    end
  end

  // Watchdog: cycles without any handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Present one request, with an optional idle burst before it
  task automatic send_request(input logic mode, input logic [TASK_W-1:0] tid,
                              input logic [COUNT_W-1:0] n);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {n, tid};
    in_tuser  = mode;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Hold off until every predicted result has come back
  task automatic wait_drain();
    in_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_initial_count(input logic [INIT_W-1:0] v);
    wait_drain();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  // Mostly waits and small signals, with some negative and large counts
  task automatic random_request();
    int                 pick;
    logic [TASK_W-1:0]  tid;
    logic [COUNT_W-1:0] junk;
    tid  = TASK_W'($urandom);
    junk = COUNT_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      send_request(MODE_WAIT, tid, junk);
    end else if (pick < 70) begin
      send_request(MODE_SIGNAL, tid, '0);
    end else if (pick < 87) begin
      send_request(MODE_SIGNAL, tid, COUNT_W'($urandom_range(1, 6)));
    end else if (pick < 93) begin
      send_request(MODE_SIGNAL, tid, {1'b1, junk[14:0]});
    end else begin
      send_request(MODE_SIGNAL, tid, {1'b0, junk[14:0]});
    end
  endtask

  initial begin
    int unsigned phase_init [6];
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = MODE_WAIT;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty queue, passes, negative counts, full queue, bulk release
    set_initial_count('0);
    send_request(MODE_SIGNAL, 8'h00, 16'sd0);
    send_request(MODE_WAIT, 8'hAA, 16'hFFFF);
    send_request(MODE_SIGNAL, 8'hFF, 16'h8000);
    send_request(MODE_SIGNAL, 8'h00, 16'hFFFF);
    send_request(MODE_WAIT, 8'hFF, 16'h0000);
    send_request(MODE_WAIT, 8'h00, 16'hFFFF);
    for (int i = 2; i < 17; i++) begin
      send_request(MODE_WAIT, TASK_W'(i * 37), COUNT_W'(i));
    end
    send_request(MODE_SIGNAL, 8'h5A, 16'sd0);
    send_request(MODE_SIGNAL, 8'hA5, 16'h7FFF);
    send_request(MODE_SIGNAL, 8'h00, 16'sd1);

    // Register change pulls the value negative with nobody queued
    set_initial_count(15'd5);
    send_request(MODE_WAIT, 8'h12, 16'sd0);
    set_initial_count('0);
    send_request(MODE_SIGNAL, 8'h00, 16'sd0);
    send_request(MODE_WAIT, 8'h34, 16'sd0);
    send_request(MODE_SIGNAL, 8'h00, 16'sd2);

    // Top of range: the value clamps at the maximum
    set_initial_count(15'h7FFF);
    send_request(MODE_SIGNAL, 8'h00, 16'sd0);
    send_request(MODE_SIGNAL, 8'h00, 16'sd3);
    send_request(MODE_WAIT, 8'h77, 16'sd0);

    // Random phases over several initial counts; the last runs without idling
    phase_init = '{3, 0, 32767, 1, $urandom_range(0, 20), 0};
    for (int p = 0; p < 6; p++) begin
      set_initial_count(INIT_W'(phase_init[p]));
      if (p == 5) quiet = 1'b1;
      repeat (PHASE_REQS) random_request();
    end

    wait_drain();
    repeat (8) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
